// ===== src/forel_pkg.sv =====
// Package for the FOREL radius clustering block: types, constants and the sequencer state.
// Used by forel_radius_clustering. No dependencies.
`default_nettype none
package forel_pkg;
   localparam int MaxPointsDef = 64;
   localparam int CoordBitsDef = 16;
   localparam int RadiusBits   = 35;
   localparam int RoundsBits   = 8;
   localparam int CsrDataBits  = 35;
   localparam int CsrIdxBits   = 1;

   localparam logic [CsrIdxBits-1:0] CsrRadius = 1'd0;
   localparam logic [CsrIdxBits-1:0] CsrRounds = 1'd1;

   localparam logic [1:0] MarkFree    = 2'd0;
   localparam logic [1:0] MarkHit     = 2'd1;
   localparam logic [1:0] MarkClaimed = 2'd2;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SEED,
      ST_MARK,
      ST_DIV,
      ST_CLAIM,
      ST_EMIT,
      ST_CLEAR
   } state_type;

   typedef enum logic [1:0] {
      PASS_SEED,
      PASS_MARK,
      PASS_CLAIM
   } pass_type;
endpackage
`default_nettype wire

// ===== src/forel_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module forel_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== src/forel_radius_clustering.sv =====
// Top level of the FOREL radius clustering block: point store, sequencer, mean divider.
// Depends on forel_pkg and forel_ram.
//
//  channel | ports                                     | handshake
//  --------+-------------------------------------------+----------------------------
//  request | req_x, req_y, req_last                    | start && !busy
//  result  | rsp_point_index, rsp_cluster_id, rsp_final_res | rsp_valid, one cycle each
//  config  | csr_write, csr_index, csr_data             | csr_write
//
// Points load at one per cycle while busy is low. On last the block goes busy and clusters:
// each memory pass reads the N points through the registered memory read, and a cluster costs
// a seed pass, up to rounds+1 mark passes and a claim pass; a mark pass with hits adds
// a restoring division for the two means.
// A last seed pass finds no free point, then the labels stream out.
// After reset the mark memory is swept clear with busy high.
`default_nettype none
module forel_radius_clustering #(
   parameter int MAX_POINTS = forel_pkg::MaxPointsDef,
   parameter int COORD_BITS = forel_pkg::CoordBitsDef
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic signed [15:0]                  req_x,
   input  wire logic signed [15:0]                  req_y,
   input  wire logic                                req_last,
   output logic                                     rsp_valid,
   output logic [5:0]                               rsp_point_index,
   output logic [5:0]                               rsp_cluster_id,
   output logic                                     rsp_final_res,
   input  wire logic                                csr_write,
   input  wire logic [forel_pkg::CsrIdxBits-1:0]    csr_index,
   input  wire logic [forel_pkg::CsrDataBits-1:0]   csr_data
);
   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = AW + 1;
   localparam int SW = COORD_BITS + AW;
   localparam int DW = 2 * COORD_BITS + 2;

   // configuration
   logic [forel_pkg::RadiusBits-1:0] radius_ff;
   logic [forel_pkg::RoundsBits-1:0] rounds_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff     <= '0;
         rounds_max_ff <= forel_pkg::RoundsBits'(64);
      end else if (csr_write) begin
         case (csr_index)
            forel_pkg::CsrRadius: radius_ff <= csr_data[forel_pkg::RadiusBits-1:0];
            forel_pkg::CsrRounds: rounds_max_ff <= csr_data[forel_pkg::RoundsBits-1:0];
            default: ;
         endcase
      end
   end

   forel_pkg::state_type state_ff, state_in;
   forel_pkg::pass_type  pass_ff, pass_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic          rd_act_ff, rd_act_in;
   logic [AW-1:0] p1_idx_ff, p2_idx_ff;
   logic          p1_vld_ff, p2_vld_ff;
   logic signed [COORD_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [6:0]    next_cl_ff, next_cl_in;
   logic [7:0]    rounds_ff, rounds_in;
   logic [AW-1:0] seed_ff, seed_in;
   logic          seed_found_ff, seed_found_in;
   logic          claimed_ff, claimed_in;
   logic signed [SW-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [CW-1:0] n_ff, n_in;
   logic [AW-1:0] clr_ff, clr_in;

   // divider: |sum| / n, restoring, one bit per cycle, x then y
   logic [SW-1:0] dq_ff, dq_in;
   logic [CW-1:0] drem_ff, drem_in;
   logic [$clog2(SW+1)-1:0] dcnt_ff, dcnt_in;
   logic          dsel_ff, dsel_in;
   logic signed [COORD_BITS-1:0] mx_ff, mx_in;

   // memories
   logic                 xy_we;
   logic [AW-1:0]        xy_wa;
   logic [DW-3:0]        xy_wd, xy_rd;
   logic [AW-1:0]        rd_addr;
   logic                 mk_we;
   logic [AW-1:0]        mk_wa;
   logic [1:0]           mk_wd, mk_rd;
   logic                 lb_we;
   logic [AW-1:0]        lb_wa;
   logic [5:0]           lb_wd, lb_rd;

   forel_ram #(.Width(2*COORD_BITS), .Depth(MAX_POINTS)) u_xy (
      .clock, .wr_en(xy_we), .wr_addr(xy_wa), .wr_data(xy_wd),
      .rd_addr(rd_addr), .rd_data(xy_rd));
   forel_ram #(.Width(2), .Depth(MAX_POINTS)) u_mark (
      .clock, .wr_en(mk_we), .wr_addr(mk_wa), .wr_data(mk_wd),
      .rd_addr(rd_addr), .rd_data(mk_rd));
   forel_ram #(.Width(6), .Depth(MAX_POINTS)) u_label (
      .clock, .wr_en(lb_we), .wr_addr(lb_wa), .wr_data(lb_wd),
      .rd_addr(rd_addr), .rd_data(lb_rd));

   // stage 1: differences and squares registered
   logic signed [COORD_BITS-1:0] px, py;
   logic signed [COORD_BITS:0]   dx, dy;
   logic [2*COORD_BITS+1:0]      sqx_ff, sqy_ff;
   logic [1:0]                   p2_mark_ff;
   logic signed [COORD_BITS-1:0] p2_x_ff, p2_y_ff;
   logic [2*COORD_BITS+2:0]      d2;
   logic                         hit;

   assign px = xy_rd[2*COORD_BITS-1:COORD_BITS];
   assign py = xy_rd[COORD_BITS-1:0];
   assign dx = (COORD_BITS+1)'(px) - (COORD_BITS+1)'(cx_ff);
   assign dy = (COORD_BITS+1)'(py) - (COORD_BITS+1)'(cy_ff);

   always_ff @(posedge clock) begin
      sqx_ff     <= (2*COORD_BITS+2)'(dx * dx);
      sqy_ff     <= (2*COORD_BITS+2)'(dy * dy);
      p2_mark_ff <= mk_rd;
      p2_x_ff    <= px;
      p2_y_ff    <= py;
   end

   // sqx arrives in the cycle after the memory data; compare in stage 2
   assign d2  = (2*COORD_BITS+3)'(sqx_ff) + (2*COORD_BITS+3)'(sqy_ff);
   assign hit = (2*COORD_BITS+3 > forel_pkg::RadiusBits)
                ? (d2 <= (2*COORD_BITS+3)'(radius_ff))
                : ((forel_pkg::RadiusBits)'(d2) <= radius_ff);

   logic          sum_neg;
   logic [CW:0]   trial;
   logic [SW-1:0] q_fix;
   logic          rem_nz;

   always_comb begin
      sum_neg = dsel_ff ? sy_ff[SW-1] : sx_ff[SW-1];
      trial   = {drem_ff, dq_ff[SW-1]} - {1'b0, n_ff};
      rem_nz  = (drem_ff != '0);
      q_fix   = sum_neg ? SW'(-(dq_ff + SW'(rem_nz))) : dq_ff;
   end

   // sequencer
   logic last_p2;
   assign last_p2 = p2_vld_ff && (CW'(p2_idx_ff) == count_ff - CW'(1));

   always_comb begin
      state_in      = state_ff;
      pass_in       = pass_ff;
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      rd_act_in     = 1'b0;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      next_cl_in    = next_cl_ff;
      rounds_in     = rounds_ff;
      seed_in       = seed_ff;
      seed_found_in = seed_found_ff;
      claimed_in    = claimed_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      n_in          = n_ff;
      clr_in        = clr_ff;
      dq_in         = dq_ff;
      drem_in       = drem_ff;
      dcnt_in       = dcnt_ff;
      dsel_in       = dsel_ff;
      mx_in         = mx_ff;
      xy_we = 1'b0; xy_wa = '0; xy_wd = {COORD_BITS'(req_x), COORD_BITS'(req_y)};
      mk_we = 1'b0; mk_wa = p2_idx_ff; mk_wd = forel_pkg::MarkFree;
      lb_we = 1'b0; lb_wa = p2_idx_ff; lb_wd = next_cl_ff[5:0];
      rd_addr = rd_ptr_ff[AW-1:0];
      busy = (state_ff != forel_pkg::ST_LOAD);

      case (state_ff)
         forel_pkg::ST_CLEAR: begin
            mk_we = 1'b1;
            mk_wa = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_POINTS - 1)) state_in = forel_pkg::ST_LOAD;
         end
         forel_pkg::ST_LOAD: begin
            if (start) begin
               if (count_ff < CW'(MAX_POINTS)) begin
                  xy_we = 1'b1;
                  xy_wa = count_ff[AW-1:0];
                  mk_we = 1'b1;
                  mk_wa = count_ff[AW-1:0];
                  count_in = count_ff + CW'(1);
               end
               if (req_last) begin
                  state_in      = forel_pkg::ST_SEED;
                  pass_in       = forel_pkg::PASS_SEED;
                  rd_ptr_in     = '0;
                  rd_act_in     = 1'b1;
                  seed_found_in = 1'b0;
               end
            end
         end
         forel_pkg::ST_SEED, forel_pkg::ST_MARK, forel_pkg::ST_CLAIM: begin
            // issue reads
            if (rd_act_ff || rd_ptr_ff == '0) begin
               if (rd_ptr_ff < count_ff - CW'(1)) begin
                  rd_ptr_in = rd_ptr_ff + CW'(1);
                  rd_act_in = 1'b1;
               end
            end
            // stage 2 retire
            if (p2_vld_ff) begin
               case (pass_ff)
                  forel_pkg::PASS_SEED: begin
                     if (!seed_found_ff && p2_mark_ff == forel_pkg::MarkFree) begin
                        seed_found_in = 1'b1;
                        seed_in = p2_idx_ff;
                        cx_in = p2_x_ff;
                        cy_in = p2_y_ff;
                     end
                  end
                  forel_pkg::PASS_MARK: begin
                     if (p2_mark_ff != forel_pkg::MarkClaimed) begin
                        mk_we = 1'b1;
                        mk_wd = hit ? forel_pkg::MarkHit : forel_pkg::MarkFree;
                        if (hit) begin
                           sx_in = sx_ff + SW'(p2_x_ff);
                           sy_in = sy_ff + SW'(p2_y_ff);
                           n_in  = n_ff + CW'(1);
                        end
                     end
                  end
                  default: begin
                     if (p2_mark_ff != forel_pkg::MarkClaimed) begin
                        mk_we = 1'b1;
                        mk_wd = hit ? forel_pkg::MarkClaimed : forel_pkg::MarkFree;
                        lb_we = hit;
                        if (hit) claimed_in = 1'b1;
                     end
                  end
               endcase
               if (last_p2) begin
                  rd_ptr_in = '0;
                  case (pass_ff)
                     forel_pkg::PASS_SEED: begin
                        sx_in = '0; sy_in = '0; n_in = '0;
                        if (seed_found_in) begin
                           state_in = forel_pkg::ST_MARK;
                           pass_in  = forel_pkg::PASS_MARK;
                           rounds_in = '0;
                           rd_act_in = 1'b1;
                        end else begin
                           state_in = forel_pkg::ST_EMIT;
                           rd_act_in = 1'b1;
                        end
                     end
                     forel_pkg::PASS_MARK: begin
                        if (n_in == '0) begin
                           state_in = forel_pkg::ST_CLAIM;
                           pass_in  = forel_pkg::PASS_CLAIM;
                           claimed_in = 1'b0;
                           rd_act_in = 1'b1;
                        end else begin
                           state_in = forel_pkg::ST_DIV;
                           dsel_in  = 1'b0;
                           dcnt_in  = '0;
                           drem_in  = '0;
                           dq_in    = sx_in[SW-1] ? SW'(-sx_in) : SW'(sx_in);
                        end
                     end
                     default: begin
                        if (!claimed_in) begin
                           mk_we = 1'b1;
                           mk_wa = seed_ff;
                           mk_wd = forel_pkg::MarkClaimed;
                           lb_we = 1'b1;
                           lb_wa = seed_ff;
                        end
                        next_cl_in = next_cl_ff + 7'd1;
                        state_in = forel_pkg::ST_SEED;
                        pass_in  = forel_pkg::PASS_SEED;
                        seed_found_in = 1'b0;
                        rd_act_in = 1'b1;
                     end
                  endcase
               end
            end
         end
         forel_pkg::ST_DIV: begin
            if (dcnt_ff == ($clog2(SW+1))'(SW)) begin
               if (!dsel_ff) begin
                  mx_in   = COORD_BITS'(q_fix);
                  dsel_in = 1'b1;
                  dcnt_in = '0;
                  drem_in = '0;
                  dq_in   = sy_ff[SW-1] ? SW'(-sy_ff) : SW'(sy_ff);
               end else begin
                  state_in  = forel_pkg::ST_CLAIM;
                  pass_in   = forel_pkg::PASS_CLAIM;
                  claimed_in = 1'b0;
                  if (!((mx_ff == cx_ff && COORD_BITS'(q_fix) == cy_ff) ||
                        rounds_ff >= rounds_max_ff)) begin
                     cx_in = mx_ff;
                     cy_in = COORD_BITS'(q_fix);
                     rounds_in = rounds_ff + 8'd1;
                     sx_in = '0; sy_in = '0; n_in = '0;
                     state_in = forel_pkg::ST_MARK;
                     pass_in  = forel_pkg::PASS_MARK;
                  end
                  rd_ptr_in = '0;
                  rd_act_in = 1'b1;
               end
            end else begin
               if (!trial[CW]) begin
                  drem_in = trial[CW-1:0];
                  dq_in   = {dq_ff[SW-2:0], 1'b1};
               end else begin
                  drem_in = {drem_ff[CW-2:0], dq_ff[SW-1]};
                  dq_in   = {dq_ff[SW-2:0], 1'b0};
               end
               dcnt_in = dcnt_ff + ($clog2(SW+1))'(1);
            end
         end
         forel_pkg::ST_EMIT: begin
            if (rd_ptr_ff < count_ff - CW'(1)) begin
               rd_ptr_in = rd_ptr_ff + CW'(1);
               rd_act_in = 1'b1;
            end
            if (p1_vld_ff) begin
               mk_we = 1'b1;
               mk_wa = p1_idx_ff;
               if (CW'(p1_idx_ff) == count_ff - CW'(1)) begin
                  state_in   = forel_pkg::ST_LOAD;
                  count_in   = '0;
                  next_cl_in = '0;
                  rd_ptr_in  = '0;
               end
            end
         end
         default: state_in = forel_pkg::ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= forel_pkg::ST_CLEAR;
         pass_ff       <= forel_pkg::PASS_SEED;
         count_ff      <= '0;
         rd_ptr_ff     <= '0;
         rd_act_ff     <= 1'b0;
         p1_vld_ff     <= 1'b0;
         p2_vld_ff     <= 1'b0;
         cx_ff         <= '0;
         cy_ff         <= '0;
         next_cl_ff    <= '0;
         clr_ff        <= '0;
         seed_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pass_ff       <= pass_in;
         count_ff      <= count_in;
         rd_ptr_ff     <= rd_ptr_in;
         rd_act_ff     <= rd_act_in;
         p1_vld_ff     <= rd_act_ff && !(p2_vld_ff && last_p2) && state_ff != forel_pkg::ST_DIV;
         p2_vld_ff     <= p1_vld_ff && !(p2_vld_ff && last_p2) && state_ff != forel_pkg::ST_EMIT;
         cx_ff         <= cx_in;
         cy_ff         <= cy_in;
         next_cl_ff    <= next_cl_in;
         clr_ff        <= clr_in;
         seed_found_ff <= seed_found_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_idx_ff  <= rd_ptr_ff[AW-1:0];
      p2_idx_ff  <= p1_idx_ff;
      rounds_ff  <= rounds_in;
      seed_ff    <= seed_in;
      claimed_ff <= claimed_in;
      sx_ff      <= sx_in;
      sy_ff      <= sy_in;
      n_ff       <= n_in;
      dq_ff      <= dq_in;
      drem_ff    <= drem_in;
      dcnt_ff    <= dcnt_in;
      dsel_ff    <= dsel_in;
      mx_ff      <= mx_in;
   end

   // results straight from the label read in emit
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= (state_ff == forel_pkg::ST_EMIT) && p1_vld_ff;
      end
      rsp_point_index <= 6'(p1_idx_ff);
      rsp_cluster_id  <= lb_rd;
      rsp_final_res   <= (CW'(p1_idx_ff) == count_ff - CW'(1));
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy || $past(state_ff == forel_pkg::ST_EMIT))
      else $error("result outside emit");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == forel_pkg::ST_LOAD) |-> count_ff <= CW'(MAX_POINTS))
      else $error("point count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == forel_pkg::ST_DIV) |-> n_ff != '0)
      else $error("divide by zero");
endmodule
`default_nettype wire
